// ===== sv/msrd_pkg.sv =====
// msrd_pkg: shared types and constants for the map stream RLE deframer.
// No dependencies; imported by the interfaces and by every module.
package msrd_pkg;

    localparam int BYTE_W      = 8;
    localparam int LEN_W       = 32;
    localparam int CFG_INDEX_W = 8;

    localparam logic [BYTE_W-1:0] DELIM_RESET = 8'd59;
    localparam logic [BYTE_W-1:0] TERM_RESET  = 8'd254;

    localparam logic [CFG_INDEX_W-1:0] CFG_DELIMITER  = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_TERMINATOR = 8'd1;

    localparam logic [2:0] RECORD_LAST = 3'd4;

    typedef enum logic [1:0] {
        SEC_ID      = 2'd0,
        SEC_DATE    = 2'd1,
        SEC_META    = 2'd2,
        SEC_RECORDS = 2'd3
    } sec_t;

    typedef enum logic [2:0] {
        KIND_ID   = 3'd0,
        KIND_DATE = 3'd1,
        KIND_META = 3'd2,
        KIND_RUN  = 3'd3,
        KIND_END  = 3'd4
    } kind_t;

    typedef struct packed {
        sec_t             section;
        logic [2:0]       record_position;
        logic [LEN_W-1:0] record_bytes;
    } parse_state_t;

    typedef struct packed {
        logic [BYTE_W-1:0] delimiter_byte;
        logic [BYTE_W-1:0] terminator_byte;
    } cfg_t;

    typedef struct packed {
        logic              valid;
        kind_t             kind;
        logic [BYTE_W-1:0] text_byte;
        logic [BYTE_W-1:0] run_value;
        logic [LEN_W-1:0]  run_length;
    } result_t;

endpackage

// ===== sv/msrd_if.sv =====
// Stream and configuration channel interfaces for the deframer.
// Depends on msrd_pkg.
interface msrd_in_if;
    import msrd_pkg::*;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface msrd_out_if;
    import msrd_pkg::*;
    logic              valid;
    logic              ready;
    logic [2:0]        kind;
    logic [BYTE_W-1:0] text_byte;
    logic [BYTE_W-1:0] run_value;
    logic [LEN_W-1:0]  run_length;

    modport source (output valid, output kind, output text_byte, output run_value,
                    output run_length, input ready);
    modport sink   (input valid, input kind, input text_byte, input run_value,
                    input run_length, output ready);
endinterface

interface msrd_cfg_if;
    import msrd_pkg::*;
    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [BYTE_W-1:0]      data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== sv/map_stream_rle_deframer.sv =====
// map_stream_rle_deframer: byte stream to tagged text bytes and pixel runs.
// Path: input reg, then combinational decode, then result reg for bytes that yield one.
// Throughput: one byte per cycle unless a stalled result holds the next result byte and rx.
// Reset (rst_n, async low): section id, record empty, both registers empty,
// delimiter 59 and terminator 254. Depends on msrd_pkg, msrd_if, msrd_parse, msrd_outreg.
module map_stream_rle_deframer
(
    input  logic       clk,
    input  logic       rst_n,
    msrd_in_if.sink    rx,
    msrd_out_if.source tx,
    msrd_cfg_if.sink   cfg
);
    import msrd_pkg::*;

    logic              in_valid_reg;
    logic [BYTE_W-1:0] in_byte_reg;
    parse_state_t      state_reg;
    parse_state_t      state_next;
    cfg_t              cfg_reg;
    result_t           res;
    logic              out_free;
    logic              step;

    assign step      = in_valid_reg && (!res.valid || out_free);
    assign rx.ready  = !in_valid_reg || step;
    assign cfg.ready = 1'b1;

    msrd_parse u_parse
    (
        .cur     (state_reg),
        .rx_byte (in_byte_reg),
        .cfg     (cfg_reg),
        .nxt     (state_next),
        .res     (res)
    );

    msrd_outreg u_outreg
    (
        .clk   (clk),
        .rst_n (rst_n),
        .load  (step && res.valid),
        .res   (res),
        .free  (out_free),
        .tx    (tx)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg              <= 1'b0;
            state_reg.section         <= SEC_ID;
            state_reg.record_position <= '0;
            state_reg.record_bytes    <= '0;
            cfg_reg.delimiter_byte    <= DELIM_RESET;
            cfg_reg.terminator_byte   <= TERM_RESET;
        end
        else
        begin
            if (rx.valid && rx.ready)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (step)
            begin
                in_valid_reg <= 1'b0;
            end
            if (step)
            begin
                state_reg <= state_next;
            end
            if (cfg.valid && cfg.ready)
            begin
                if (cfg.index == CFG_DELIMITER)
                begin
                    cfg_reg.delimiter_byte <= cfg.data;
                end
                else if (cfg.index == CFG_TERMINATOR)
                begin
                    cfg_reg.terminator_byte <= cfg.data;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx.valid && rx.ready)
        begin
            in_byte_reg <= rx.rx_byte;
        end
    end

endmodule

// ===== sv/msrd_parse.sv =====
// msrd_parse: per-byte section/record decode, next state and result.
// Purely combinational; depends on msrd_pkg.
module msrd_parse
(
    input  msrd_pkg::parse_state_t     cur,
    input  logic [msrd_pkg::BYTE_W-1:0] rx_byte,
    input  msrd_pkg::cfg_t             cfg,
    output msrd_pkg::parse_state_t     nxt,
    output msrd_pkg::result_t          res
);
    import msrd_pkg::*;

    logic [LEN_W-1:0] term4;
    logic             is_end;

    assign term4  = {4{cfg.terminator_byte}};
    assign is_end = (cur.record_bytes == term4) && (rx_byte == cfg.terminator_byte);

    always_comb
    begin
        nxt            = cur;
        res.valid      = 1'b0;
        res.kind       = KIND_ID;
        res.text_byte  = '0;
        res.run_value  = '0;
        res.run_length = '0;
        if (cur.section != SEC_RECORDS)
        begin
            if (rx_byte == cfg.delimiter_byte)
            begin
                nxt.section         = sec_t'(2'(cur.section) + 2'd1);
                nxt.record_position = '0;
                nxt.record_bytes    = '0;
            end
            else
            begin
                res.valid     = 1'b1;
                res.kind      = kind_t'({1'b0, 2'(cur.section)});
                res.text_byte = rx_byte;
            end
        end
        else if (cur.record_position < RECORD_LAST)
        begin
            nxt.record_bytes    = {cur.record_bytes[LEN_W-BYTE_W-1:0], rx_byte};
            nxt.record_position = cur.record_position + 3'd1;
        end
        else
        begin
            nxt.record_position = '0;
            nxt.record_bytes    = '0;
            res.valid           = 1'b1;
            if (is_end)
            begin
                nxt.section = SEC_ID;
                res.kind    = KIND_END;
            end
            else
            begin
                res.kind       = KIND_RUN;
                res.run_value  = cur.record_bytes[LEN_W-1 -: BYTE_W];
                res.run_length = {cur.record_bytes[LEN_W-BYTE_W-1:0], rx_byte};
            end
        end
    end

endmodule

// ===== sv/msrd_outreg.sv =====
// msrd_outreg: result register driving the output channel.
// Depends on msrd_pkg and msrd_out_if.
module msrd_outreg
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  msrd_pkg::result_t res,
    output logic              free,
    msrd_out_if.source        tx
);
    import msrd_pkg::*;

    logic              valid_reg;
    logic [2:0]        kind_reg;
    logic [BYTE_W-1:0] text_reg;
    logic [BYTE_W-1:0] value_reg;
    logic [LEN_W-1:0]  length_reg;

    assign free = !valid_reg || tx.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (tx.ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            kind_reg   <= 3'(res.kind);
            text_reg   <= res.text_byte;
            value_reg  <= res.run_value;
            length_reg <= res.run_length;
        end
    end

    assign tx.valid      = valid_reg;
    assign tx.kind       = kind_reg;
    assign tx.text_byte  = text_reg;
    assign tx.run_value  = value_reg;
    assign tx.run_length = length_reg;

endmodule

// ===== verif/map_stream_rle_deframer_tb.sv =====
`timescale 1ns / 1ps
// map_stream_rle_deframer_tb: self-checking bench for the map stream RLE deframer.
// Sends byte requests and register writes, predicts every result and checks it in order.
// Depends on msrd_pkg, msrd_if and map_stream_rle_deframer.
module map_stream_rle_deframer_tb;
    import msrd_pkg::*;

    localparam int IDLE_LIMIT    = 4000;
    localparam int SETTLE_CYCLES = 8;
    localparam int PHASE_ITEMS   = 350;

    localparam int STALL_NONE  = 0;
    localparam int STALL_HEAVY = 1;
    localparam int STALL_LIGHT = 2;

    typedef struct packed {
        kind_t             kind;
        logic [BYTE_W-1:0] text_byte;
        logic [BYTE_W-1:0] run_value;
        logic [LEN_W-1:0]  run_length;
    } map_result_t;

    logic clk = 1'b0;
    logic rst_n;

    msrd_in_if  rx_bus ();
    msrd_out_if tx_bus ();
    msrd_cfg_if cfg_bus ();

    map_stream_rle_deframer dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .rx    (rx_bus),
        .tx    (tx_bus),
        .cfg   (cfg_bus)
    );

    // predicted deframer state
    logic [BYTE_W-1:0] model_delim;
    logic [BYTE_W-1:0] model_term;
    sec_t              model_section;
    logic [2:0]        model_pos;
    logic [LEN_W-1:0]  model_word;
    map_result_t       expected_q[$];

    int errors      = 0;
    int idle_cycles = 0;
    int items_sent  = 0;
    int burst_left  = 0;
    int gap_max     = 0;
    int burst_max   = 1;
    int stall_mode  = STALL_NONE;

    logic [31:0] stall_bits = '0;
    logic [3:0]  stall_step = '0;
    map_result_t got_want;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic void expect_result(input map_result_t r);
        expected_q = {expected_q, r};
    endfunction

    function automatic void predict_byte(input logic [BYTE_W-1:0] b);
        map_result_t r;
        r = '0;
        if (model_section != SEC_RECORDS)
        begin
            if (b == model_delim)
            begin
                model_section = sec_t'(model_section + 2'd1);
                model_pos     = '0;
                model_word    = '0;
            end
            else
            begin
                r.kind      = kind_t'({1'b0, model_section});
                r.text_byte = b;
                expect_result(r);
            end
        end
        else if (model_pos < RECORD_LAST)
        begin
            model_word = {model_word[LEN_W-BYTE_W-1:0], b};
            model_pos  = model_pos + 3'd1;
        end
        else
        begin
            if (model_word == {4{model_term}} && b == model_term)
            begin
                r.kind        = KIND_END;
                model_section = SEC_ID;
            end
            else
            begin
                r.kind       = KIND_RUN;
                r.run_value  = model_word[LEN_W-1 -: BYTE_W];
                r.run_length = {model_word[LEN_W-BYTE_W-1:0], b};
            end
            model_pos  = '0;
            model_word = '0;
            expect_result(r);
        end
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t: %s mismatch, got %0h, expected %0h", $time, what, got, want);
        errors++;
    endtask

    task automatic send_byte(input logic [BYTE_W-1:0] b);
        int gap;
        if (burst_left == 0)
        begin
            gap        = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
            burst_left = $urandom_range(1, burst_max);
            if (gap > 0)
            begin
                rx_bus.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        rx_bus.valid   <= 1'b1;
        rx_bus.rx_byte <= b;
        @(posedge clk);
        while (!rx_bus.ready) @(posedge clk);
        predict_byte(b);
        burst_left--;
        items_sent++;
    endtask

    task automatic send_record(input logic [BYTE_W-1:0] value, input logic [LEN_W-1:0] length);
        send_byte(value);
        for (int i = 3; i >= 0; i--)
            send_byte(length[8*i +: 8]);
    endtask

    // sender holds off until every pending result is out and the pipe is empty
    task automatic wait_drained();
        rx_bus.valid <= 1'b0;
        burst_left = 0;
        while (expected_q.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input logic [CFG_INDEX_W-1:0] index,
                                  input logic [BYTE_W-1:0] value);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= index;
        cfg_bus.data  <= value;
        @(posedge clk);
        while (!cfg_bus.ready) @(posedge clk);
        if (index == CFG_DELIMITER)
            model_delim = value;
        else if (index == CFG_TERMINATOR)
            model_term = value;
    endtask

    task automatic configure(input logic [BYTE_W-1:0] delim, input logic [BYTE_W-1:0] term);
        wait_drained();
        write_register(CFG_DELIMITER, delim);
        write_register(CFG_TERMINATOR, term);
        // unmapped index must be dropped
        write_register(CFG_INDEX_W'($urandom_range(CFG_TERMINATOR + 1, 255)),
                       BYTE_W'($urandom_range(0, 255)));
        cfg_bus.valid <= 1'b0;
    endtask

    task automatic set_pace(input int gaps, input int bursts, input int stalls);
        gap_max    = gaps;
        burst_max  = bursts;
        stall_mode = stalls;
    endtask

    function automatic logic [BYTE_W-1:0] pick_text_byte();
        logic [BYTE_W-1:0] b;
        b = ($urandom_range(0, 7) == 0) ? model_term : BYTE_W'($urandom_range(0, 255));
        while (b == model_delim) b = BYTE_W'($urandom_range(0, 255));
        return b;
    endfunction

    function automatic logic [BYTE_W-1:0] pick_record_byte();
        case ($urandom_range(0, 7))
            0:       return model_term;
            1:       return model_delim;
            default: return BYTE_W'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [LEN_W-1:0] pick_run_length();
        case ($urandom_range(0, 4))
            0:       return $urandom_range(0, 255);
            1:       return '1;
            2:       return '0;
            3:       return {{3{model_term}}, pick_record_byte()};
            default: return $urandom;
        endcase
    endfunction

    task automatic send_message();
        int n;
        // realign to a record boundary and close the map if parked in records
        if (model_section == SEC_RECORDS)
        begin
            while (model_pos != 0) send_byte(BYTE_W'($urandom_range(0, 255)));
            if (model_section == SEC_RECORDS)
                repeat (5) send_byte(model_term);
        end
        for (int s = int'(model_section); s < int'(SEC_RECORDS); s++)
        begin
            n = $urandom_range(0, (s == int'(SEC_META)) ? 10 : 5);
            repeat (n) send_byte(pick_text_byte());
            send_byte(model_delim);
        end
        n = $urandom_range(0, 10);
        repeat (n) send_record(pick_record_byte(), pick_run_length());
        repeat (5) send_byte(model_term);
    endtask

    task automatic send_noise(input int count);
        repeat (count)
        begin
            case ($urandom_range(0, 3))
                0:       send_byte(model_delim);
                1:       send_byte(model_term);
                default: send_byte(BYTE_W'($urandom_range(0, 255)));
            endcase
        end
    endtask

    task automatic test_directed_defaults();
        set_pace(3, 6, STALL_HEAVY);
        send_byte(8'hFE);
        send_byte(8'h00);
        send_byte(DELIM_RESET);
        send_byte(8'hFF);
        send_byte(DELIM_RESET);
        send_byte(DELIM_RESET);
        // delimiter as record data, then five terminator bytes across two records
        send_record(DELIM_RESET, {4{TERM_RESET}});
        send_record(TERM_RESET, 32'hFFFF_FFFF);
        repeat (5) send_byte(TERM_RESET);
    endtask

    task automatic test_equal_registers();
        configure(8'hA5, 8'hA5);
        set_pace(2, 4, STALL_LIGHT);
        repeat (3) send_byte(8'hA5);
        repeat (5) send_byte(8'hA5);
    endtask

    task automatic test_random_traffic(input logic [BYTE_W-1:0] delim,
                                       input logic [BYTE_W-1:0] term,
                                       input int gaps, input int bursts, input int stalls);
        int target;
        int pick;
        configure(delim, term);
        set_pace(gaps, bursts, stalls);
        target = items_sent + PHASE_ITEMS;
        while (items_sent < target)
        begin
            pick = $urandom_range(0, 19);
            if (pick < 15)
                send_message();
            else if (pick < 19)
                send_noise($urandom_range(1, 12));
            else
                wait_drained();
        end
    endtask

    initial
    begin
        logic [BYTE_W-1:0] shared;
        rst_n          <= 1'b0;
        rx_bus.valid   <= 1'b0;
        rx_bus.rx_byte <= '0;
        cfg_bus.valid  <= 1'b0;
        cfg_bus.index  <= '0;
        cfg_bus.data   <= '0;
        model_delim    = DELIM_RESET;
        model_term     = TERM_RESET;
        model_section  = SEC_ID;
        model_pos      = '0;
        model_word     = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_defaults();
        test_equal_registers();
        test_random_traffic(DELIM_RESET, TERM_RESET, 0, 64, STALL_NONE);
        test_random_traffic(8'h00, 8'hFF, 6, 8, STALL_HEAVY);
        test_random_traffic(8'hFF, 8'h00, 3, 20, STALL_LIGHT);
        test_random_traffic(BYTE_W'($urandom_range(0, 255)), BYTE_W'($urandom_range(0, 255)),
                            10, 4, STALL_HEAVY);
        shared = BYTE_W'($urandom_range(0, 255));
        test_random_traffic(shared, shared, 2, 30, STALL_LIGHT);

        stall_mode = STALL_NONE;
        wait_drained();
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    always @(posedge clk)
    begin
        if (stall_step == 4'd0)
            stall_bits = $urandom;
        case (stall_mode)
            STALL_NONE:  tx_bus.ready <= 1'b1;
            STALL_HEAVY: tx_bus.ready <= stall_bits[{1'b0, stall_step}];
            default:     tx_bus.ready <= stall_bits[{1'b0, stall_step}]
                                         | stall_bits[{1'b1, stall_step}];
        endcase
        stall_step = stall_step + 4'd1;
    end

    always @(posedge clk)
    begin
        if (rst_n && tx_bus.valid && tx_bus.ready)
        begin
            if (expected_q.size() == 0)
                report_mismatch("unexpected result kind", 32'(tx_bus.kind), 32'd0);
            else
            begin
                got_want = expected_q.pop_front();
                if (tx_bus.kind !== got_want.kind)
                    report_mismatch("kind", 32'(tx_bus.kind), 32'(got_want.kind));
                if (tx_bus.text_byte !== got_want.text_byte)
                    report_mismatch("text_byte", 32'(tx_bus.text_byte),
                                    32'(got_want.text_byte));
                if (tx_bus.run_value !== got_want.run_value)
                    report_mismatch("run_value", 32'(tx_bus.run_value),
                                    32'(got_want.run_value));
                if (tx_bus.run_length !== got_want.run_length)
                    report_mismatch("run_length", tx_bus.run_length, got_want.run_length);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((rx_bus.valid && rx_bus.ready) || (tx_bus.valid && tx_bus.ready)
            || (cfg_bus.valid && cfg_bus.ready))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

endmodule

// ===== sim.f =====
sv/msrd_pkg.sv
sv/msrd_if.sv
sv/msrd_parse.sv
sv/msrd_outreg.sv
sv/map_stream_rle_deframer.sv
verif/map_stream_rle_deframer_tb.sv
